>>> rtl/las_pkg.sv
// Shared types, constants and microcode for the longest arithmetic subsequence block.
`default_nettype none

package las_pkg;

    localparam int VALUE_W = 8;   // width of the value field on the input channel
    localparam int LEN_W   = 9;   // width of the length field on the result channel
    localparam int RUN_W   = 8;   // width of one run table entry
    localparam int EPOCH_W = 8;   // sequence tag stored beside each run table entry

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } result_t;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_CHECK = 3'd2,
        ST_LOOP  = 3'd3,
        ST_DRAIN = 3'd4,
        ST_TAIL  = 3'd5,
        ST_EMIT  = 3'd6,
        ST_WRAP  = 3'd7
    } step_t;

    // Branch conditions a control word can test
    typedef enum logic [2:0] {
        C_GOTO       = 3'd0,
        C_IN_XFER    = 3'd1,
        C_CLR_LAST   = 3'd2,
        C_ROOM       = 3'd3,
        C_ISSUE_DONE = 3'd4,
        C_LAST       = 3'd5,
        C_OUT_FREE   = 3'd6,
        C_EPOCH_WRAP = 3'd7
    } cond_t;

    typedef struct packed {
        logic  in_ready;  // open the input channel
        logic  clr_we;    // write one cleared run table entry
        logic  admit;     // store the held item, or mark it dropped
        logic  issue;     // start one comparison against an earlier item
        logic  bump;      // close the row of the current item
        logic  emit;      // load the result register and start a new sequence
        cond_t cond;
        step_t jmp_t;
        step_t jmp_f;
    } ctrl_t;

    typedef struct packed {
        logic in_xfer;
        logic clr_last;
        logic room;
        logic issue_done;
        logic last;
        logic out_free;
        logic epoch_wrap;
    } flags_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t cw;
        cw = '{in_ready: 1'b0, clr_we: 1'b0, admit: 1'b0, issue: 1'b0, bump: 1'b0,
               emit: 1'b0, cond: C_GOTO, jmp_t: ST_IDLE, jmp_f: ST_IDLE};
        case (step)
            ST_CLEAR:
            begin
                cw.clr_we = 1'b1;
                cw.cond   = C_CLR_LAST;
                cw.jmp_t  = ST_IDLE;
                cw.jmp_f  = ST_CLEAR;
            end
            ST_IDLE:
            begin
                cw.in_ready = 1'b1;
                cw.cond     = C_IN_XFER;
                cw.jmp_t    = ST_CHECK;
                cw.jmp_f    = ST_IDLE;
            end
            ST_CHECK:
            begin
                cw.admit = 1'b1;
                cw.cond  = C_ROOM;
                cw.jmp_t = ST_LOOP;
                cw.jmp_f = ST_TAIL;
            end
            ST_LOOP:
            begin
                cw.issue = 1'b1;
                cw.cond  = C_ISSUE_DONE;
                cw.jmp_t = ST_DRAIN;
                cw.jmp_f = ST_LOOP;
            end
            ST_DRAIN:
            begin
                cw.bump  = 1'b1;
                cw.cond  = C_GOTO;
                cw.jmp_t = ST_TAIL;
                cw.jmp_f = ST_TAIL;
            end
            ST_TAIL:
            begin
                cw.cond  = C_LAST;
                cw.jmp_t = ST_EMIT;
                cw.jmp_f = ST_IDLE;
            end
            ST_EMIT:
            begin
                cw.emit  = 1'b1;
                cw.cond  = C_OUT_FREE;
                cw.jmp_t = ST_WRAP;
                cw.jmp_f = ST_EMIT;
            end
            ST_WRAP:
            begin
                cw.cond  = C_EPOCH_WRAP;
                cw.jmp_t = ST_CLEAR;
                cw.jmp_f = ST_IDLE;
            end
            default:
            begin
                cw.cond  = C_GOTO;
                cw.jmp_t = ST_IDLE;
                cw.jmp_f = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

>>> rtl/las_stream_if.sv
// Valid/ready stream channel carrying one payload of a chosen type.
`default_nettype none

interface las_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/longest_arith_subseq_dp_top.sv
// Top level of the longest arithmetic subsequence block (run table DP, microcoded control).
//
// Usage: values arrive on the item channel (value, last), one transfer per element of a
// sequence; last marks the final element. One result transfer (length, overflow) follows
// each item with last set. Elements beyond MAX_ITEMS in one sequence are dropped and
// reported through overflow.
// Flow: an element that finds k elements already held keeps the item channel closed
// through the check, loop, drain and tail steps after its transfer, so no new element
// is taken meanwhile; the loop over the k earlier elements runs one comparison per cycle
// through a three-stage pipeline of value store read, run table read and run table
// write, and the single port pair of the run table sets that rate. A dropped element
// keeps the channel closed through the check and tail steps. A last element adds the
// emit and wrap steps: its result register loads in the emit step once it is free.
// Reset: the run table is swept to zero, one entry a cycle, MAX_ITEMS * 2^(VALUE_BITS+1)
// entries (131072 at the default sizes), with the item channel closed. Each entry
// carries a sequence tag, so a new sequence needs no clearing; when the tag wraps,
// every 255 sequences, the same sweep runs again.
// Stalls: the result register holds its transfer until the receiver takes it; further
// elements are still accepted meanwhile, and only a following last element waits for
// the register to empty.
`default_nettype none

module longest_arith_subseq_dp_top
    import las_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int VALUE_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    las_stream_if.sink   item,
    las_stream_if.source result
);

    localparam int ROW_BITS  = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int COL_BITS  = VALUE_BITS + 1;
    localparam int TAB_AW    = ROW_BITS + COL_BITS;
    localparam int TAB_DEPTH = MAX_ITEMS << COL_BITS;
    localparam int TAB_W     = EPOCH_W + RUN_W;
    localparam int EXT_W     = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    // Control
    ctrl_t  cw;
    flags_t flags;
    logic   in_xfer;
    logic   out_free;
    logic   room;
    logic   issue_fire;

    // Sequence state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [RUN_W-1:0]   best_reg, best_next;
    logic               drop_reg, drop_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [TAB_AW-1:0]  clr_addr_reg, clr_addr_next;

    // Held item
    logic [EXT_W-1:0]      val_ext;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  last_reg;

    // Comparison pipeline
    logic                  s1_valid_reg;
    logic [ROW_BITS-1:0]   s1_j_reg;
    logic                  s2_valid_reg;
    logic [COL_BITS-1:0]   s2_col_reg;
    logic [VALUE_BITS-1:0] vs_rdata;
    logic [COL_BITS-1:0]   s1_col;
    logic [TAB_W-1:0]      tab_rdata;
    logic [RUN_W-1:0]      run_old;
    logic [RUN_W-1:0]      run_new;

    // Run table write port
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [TAB_W-1:0]  tab_wdata;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    out_load;

    las_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    assign item.ready = cw.in_ready;
    assign in_xfer    = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign room       = count_reg < CNT_W'(MAX_ITEMS);
    assign issue_fire = cw.issue && (j_reg != count_reg);
    assign out_load   = cw.emit && out_free;

    always_comb
    begin
        flags.in_xfer    = in_xfer;
        flags.clr_last   = clr_addr_reg == TAB_AW'(TAB_DEPTH - 1);
        flags.room       = room;
        flags.issue_done = j_reg == count_reg;
        flags.last       = last_reg;
        flags.out_free   = out_free;
        flags.epoch_wrap = epoch_reg == '0;
    end

    // Keep only the low VALUE_BITS of the incoming value
    assign val_ext = EXT_W'(item.data.value);

    // Value store: written once per admitted item, read once per comparison
    las_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_value_store (
        .clk   (clk),
        .we    (cw.admit && room),
        .waddr (count_reg[ROW_BITS-1:0]),
        .wdata (val_reg),
        .raddr (j_reg[ROW_BITS-1:0]),
        .rdata (vs_rdata)
    );

    // Column: difference shifted by half the range; adding 2^VALUE_BITS flips the top bit
    always_comb
    begin
        s1_col = (COL_BITS'(val_reg) - COL_BITS'(vs_rdata))
                 ^ {1'b1, {VALUE_BITS{1'b0}}};
    end

    // Run table: entry is {epoch tag, run}; a tag from another sequence reads as zero
    las_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TAB_DEPTH)
    ) u_run_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr ({s1_j_reg, s1_col}),
        .rdata (tab_rdata)
    );

    always_comb
    begin
        run_old = (tab_rdata[TAB_W-1:RUN_W] == epoch_reg) ? tab_rdata[RUN_W-1:0] : '0;
        run_new = (run_old == RUN_MAX) ? RUN_MAX : run_old + RUN_W'(1);
    end

    // The sweep and the comparison pipeline never run together
    always_comb
    begin
        tab_we = cw.clr_we || s2_valid_reg;
        if (cw.clr_we)
        begin
            tab_waddr = clr_addr_reg;
            tab_wdata = '0;
        end
        else
        begin
            tab_waddr = {count_reg[ROW_BITS-1:0], s2_col_reg};
            tab_wdata = {epoch_reg, run_new};
        end
    end

    // Sequence state update
    always_comb
    begin
        count_next    = count_reg;
        j_next        = j_reg;
        best_next     = best_reg;
        drop_next     = drop_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;

        if (cw.clr_we)
        begin
            if (flags.clr_last)
            begin
                clr_addr_next = '0;
                epoch_next    = EPOCH_W'(1);
            end
            else
            begin
                clr_addr_next = clr_addr_reg + TAB_AW'(1);
            end
        end

        if (cw.admit)
        begin
            if (room)
            begin
                j_next = '0;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        if (issue_fire)
        begin
            j_next = j_reg + CNT_W'(1);
        end

        if (s2_valid_reg && (run_new > best_reg))
        begin
            best_next = run_new;
        end

        if (cw.bump)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        // Start a fresh sequence once the result is loaded
        if (out_load)
        begin
            count_next = '0;
            best_next  = '0;
            drop_next  = 1'b0;
            epoch_next = epoch_reg + EPOCH_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            j_reg         <= '0;
            best_reg      <= '0;
            drop_reg      <= 1'b0;
            epoch_reg     <= EPOCH_W'(1);
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            j_reg         <= j_next;
            best_reg      <= best_next;
            drop_reg      <= drop_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= issue_fire;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            val_reg  <= val_ext[VALUE_BITS-1:0];
            last_reg <= item.data.last;
        end
        s1_j_reg   <= j_reg[ROW_BITS-1:0];
        s2_col_reg <= s1_col;
        if (out_load)
        begin
            out_data_reg.length   <= LEN_W'(best_reg) + LEN_W'(1);
            out_data_reg.overflow <= drop_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // The clearing sweep owns the run table write port alone
    assert property (@(posedge clk) disable iff (!rst_n)
        cw.clr_we |-> !s1_valid_reg && !s2_valid_reg)
    else $error("run table sweep overlaps a comparison");

    // No comparison is in flight while a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !s1_valid_reg && !s2_valid_reg && !cw.issue)
    else $error("item channel open during comparison loop");

    // Item count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond capacity");

    // A result appears only from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cw.emit))
    else $error("result loaded outside emit step");

endmodule

`default_nettype wire

>>> rtl/las_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module las_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/las_seq.sv
// Microcode sequencer: step counter, control word ROM and conditional branch.
`default_nettype none

module las_seq
    import las_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       cw
);

    step_t step_reg;
    step_t step_next;
    logic  cond_ok;

    // Outputs: the control word of the current step
    always_comb
    begin
        cw = ucode_rom(step_reg);
    end

    // Next step: pick the tested flag, then branch
    always_comb
    begin
        case (cw.cond)
            C_GOTO:       cond_ok = 1'b1;
            C_IN_XFER:    cond_ok = flags.in_xfer;
            C_CLR_LAST:   cond_ok = flags.clr_last;
            C_ROOM:       cond_ok = flags.room;
            C_ISSUE_DONE: cond_ok = flags.issue_done;
            C_LAST:       cond_ok = flags.last;
            C_OUT_FREE:   cond_ok = flags.out_free;
            C_EPOCH_WRAP: cond_ok = flags.epoch_wrap;
            default:      cond_ok = 1'b1;
        endcase
        step_next = cond_ok ? cw.jmp_t : cw.jmp_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the longest arithmetic subsequence block.
module testbench
    import las_pkg::*;
();

    // Block sizes under test; the predictor below is written for the same sizes.
    localparam int ITEM_CAP     = 256;
    localparam int VAL_BITS     = 8;
    localparam int VAL_MASK     = (1 << VAL_BITS) - 1;
    localparam int DIFF_OFFSET  = 1 << VAL_BITS;
    localparam int DIFF_COLS    = 2 << VAL_BITS;
    localparam int RUN_CEIL     = 255;
    localparam int LEN_CEIL     = 511;

    // Every tag wrap costs a full table sweep and a full sequence runs a long comparison
    // loop, so the limit leaves several times the slowest expected run.
    localparam int CYCLE_LIMIT  = 4_000_000;
    // Longest gap from the last item transfer to a result: a full row plus overhead.
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 130;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    las_stream_if #(.payload_t(item_t))   item_ch ();
    las_stream_if #(.payload_t(result_t)) result_ch ();

    longest_arith_subseq_dp_top #(
        .MAX_ITEMS  (ITEM_CAP),
        .VALUE_BITS (VAL_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Traffic shaping knobs, changed by the test tasks between phases.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    // Cycles the receiver still holds ready low; counted down by the receiver process.
    int hold_left          = 0;
    int mismatches         = 0;
    int cycle_count        = 0;

    // Results owed by the block, oldest first.
    result_t length_queue[$];
    result_t want;

    // Predictor state: values held in this sequence and the run table rows.
    logic [VAL_BITS-1:0] held_vals [ITEM_CAP];
    logic [RUN_W-1:0]    run_tab   [ITEM_CAP][DIFF_COLS];
    int                  held_count  = 0;
    int                  longest_run = 0;
    logic                dropped_any = 1'b0;

    // Advance the predictor by one accepted item; queue a result on the last one.
    function automatic void extend_runs(input logic [VALUE_W-1:0] val, input logic is_last);
        int v;
        int row;
        int col;
        int run;
        int len;
        int c;
        int j;
        result_t r;
        v = int'(val) & VAL_MASK;
        if (held_count < ITEM_CAP)
        begin
            row = held_count;
            for (c = 0; c < DIFF_COLS; c++)
                run_tab[row][c] = '0;
            held_vals[row] = VAL_BITS'(v);
            // Each earlier value extends the run that ended on it with this difference.
            for (j = 0; j < row; j++)
            begin
                col = (v + DIFF_OFFSET - int'(held_vals[j])) & (DIFF_COLS - 1);
                run = int'(run_tab[j][col]) + 1;
                if (run > RUN_CEIL)
                    run = RUN_CEIL;
                run_tab[row][col] = RUN_W'(run);
                if (run > longest_run)
                    longest_run = run;
            end
            held_count = row + 1;
        end
        else
        begin
            // No room left: drop the item, but remember it for the overflow flag.
            dropped_any = 1'b1;
        end
        if (is_last)
        begin
            len = longest_run + 1;
            if (len > LEN_CEIL)
                len = LEN_CEIL;
            r.length   = LEN_W'(len);
            r.overflow = dropped_any;
            length_queue.push_back(r);
            held_count  = 0;
            longest_run = 0;
            dropped_any = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, exp_val);
    endtask

    // Check every result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (length_queue.size() == 0)
            begin
                report_mismatch("result with none owed", int'(result_ch.data.length), 0);
            end
            else
            begin
                want = length_queue.pop_front();
                if (result_ch.data.length !== want.length)
                    report_mismatch("length", int'(result_ch.data.length), int'(want.length));
                if (result_ch.data.overflow !== want.overflow)
                    report_mismatch("overflow", int'(result_ch.data.overflow),
                                    int'(want.overflow));
            end
        end
    end

    // Receiver: hold off while a hold is pending, else stall at the phase rate.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: fail the run at the cycle limit, which catches a block that stops making progress.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offer one item and wait for its transfer. Valid stays high on return so that
    // back-to-back items need no dead cycle; release_items drops it before any pause.
    task automatic send_item(input logic [VALUE_W-1:0] val, input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= item_t'{value: val, last: is_last};
        do
            @(posedge clk);
        while (!item_ch.ready);
        extend_runs(val, is_last);
    endtask

    task automatic release_items();
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_items();
        while (length_queue.size() != 0)
            @(negedge clk);
    endtask

    // Send a fixed list as one sequence; mark the final entry last.
    task automatic send_values(input logic [VALUE_W-1:0] vals[$]);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // One sequence of random shape: noise, a progression with some noise mixed in,
    // a narrow cluster of values, or values near the extremes.
    task automatic send_random_sequence(input int len);
        int mode;
        int base;
        int stride;
        int i;
        logic [VALUE_W-1:0] v;
        mode   = $urandom_range(3);
        base   = $urandom_range(255);
        stride = $urandom_range(255);
        for (i = 0; i < len; i++)
        begin
            case (mode)
                0: v = VALUE_W'($urandom_range(255));
                1:
                begin
                    v = VALUE_W'(base + stride * i);
                    if ($urandom_range(5) == 0)
                        v = VALUE_W'($urandom_range(255));
                end
                2: v = VALUE_W'(base + $urandom_range(2));
                default:
                begin
                    v = $urandom_range(1) ? '1 : '0;
                    if ($urandom_range(3) == 0)
                        v[$urandom_range(VALUE_W - 1)] = ~v[$urandom_range(VALUE_W - 1)];
                end
            endcase
            send_item(v, i == len - 1);
        end
    endtask

    // Lone item, extreme differences both ways, constant, rising and falling progressions, and a mixed list.
    task automatic test_basic_sequences();
        logic [VALUE_W-1:0] seq[$];
        seq = '{8'd7};
        send_values(seq);
        seq = '{8'd0, 8'd255};
        send_values(seq);
        seq = '{8'd255, 8'd0};
        send_values(seq);
        seq = '{8'd9, 8'd9, 8'd9, 8'd9};
        send_values(seq);
        seq = '{8'd0, 8'd85, 8'd170, 8'd255};
        send_values(seq);
        seq = '{8'd255, 8'd170, 8'd85, 8'd0};
        send_values(seq);
        seq = '{8'hAA, 8'h55};
        send_values(seq);
        seq = '{8'd3, 8'd1, 8'd4, 8'd1, 8'd5, 8'd9};
        send_values(seq);
    endtask

    // Fill the table exactly: 0..255 gives the longest possible run, no overflow.
    task automatic test_full_capacity();
        int i;
        for (i = 0; i < ITEM_CAP; i++)
            send_item(VALUE_W'(i), i == ITEM_CAP - 1);
    endtask

    // Run past capacity so the marked item itself is dropped; the next sequence
    // must start with the overflow flag clear.
    task automatic test_overflow_drop();
        logic [VALUE_W-1:0] seq[$];
        send_random_sequence(ITEM_CAP + 4);
        seq = '{8'd42};
        send_values(seq);
    endtask

    // Hold the receiver off long enough that the result register stays full and a
    // following last item backs up the item channel.
    task automatic test_result_backpressure();
        logic [VALUE_W-1:0] seq[$];
        wait_drained();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 1500;
        seq = '{8'd10, 8'd20, 8'd30};
        send_values(seq);
        seq = '{8'd1, 8'd2};
        send_values(seq);
        seq = '{8'd5};
        send_values(seq);
        wait_drained();
    endtask

    // Random sequences across the idle/stall phases; mostly short, a few long
    // enough to reach or pass capacity.
    task automatic test_random_sequences();
        int idle_plan[5];
        int stall_plan[5];
        int p;
        int sent;
        int len;
        int pick;
        idle_plan  = '{0, 85, 0, 25, 0};
        stall_plan = '{0, 0, 85, 25, 0};
        for (p = 0; p < 5; p++)
        begin
            sender_idle_pct    = idle_plan[p];
            receiver_stall_pct = stall_plan[p];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 86)
                    len = $urandom_range(6, 1);
                else if (pick < 98)
                    len = $urandom_range(40, 7);
                else
                    len = $urandom_range(300, 41);
                send_random_sequence(len);
                sent += len;
            end
        end
    endtask

    // Enough short sequences to wrap the sequence tag and force a table sweep;
    // stale entries from earlier sequences must not leak into new runs.
    task automatic test_tag_wrap();
        int s;
        sender_idle_pct    = 0;
        receiver_stall_pct = 25;
        for (s = 0; s < 300; s++)
            send_random_sequence($urandom_range(3, 1));
    endtask

    initial
    begin
        // Hold every block input at a known value until the tests take over.
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_sequences();
        test_full_capacity();
        test_overflow_drop();
        test_result_backpressure();
        test_random_sequences();
        test_tag_wrap();

        // Drain: let every owed result arrive, then idle out the block's latency.
        receiver_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && length_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/las_pkg.sv
rtl/las_stream_if.sv
rtl/las_ram.sv
rtl/las_seq.sv
rtl/longest_arith_subseq_dp_top.sv
tb/testbench.sv
